// File: design/pbl_pkg.sv
// Shared types and constants for the pivot basis label map.
// Used by the channel interfaces and by every module of the block but pbl_ram.
package pbl_pkg;

    localparam int OP_W    = 3;
    localparam int LABEL_W = 6;
    localparam int ROW_W   = 5;

    localparam logic [OP_W-1:0] OP_PIVOT  = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK   = 3'd3;
    localparam logic [OP_W-1:0] OP_UNMARK = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd5;

    // Work the back end has to do for one beat.
    typedef enum logic [2:0] {
        K_PIVOT,
        K_LOOKUP,
        K_READ,
        K_MARK,
        K_UNMARK,
        K_ERROR,
        K_EMPTY
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [LABEL_W-1:0]  label;
        logic [ROW_W-1:0]           row;
    } t_cmd;

    // One entry of the label map: blocked mark and the row holding the label.
    typedef struct packed {
        logic               blk;
        logic [ROW_W-1:0]   row;
    } t_lm;

    typedef struct packed {
        logic signed [LABEL_W-1:0]  out_label;
        logic [ROW_W-1:0]           row_index;
        logic                       is_member;
        logic                       is_blocked;
        logic                       is_identity;
        logic                       error;
    } t_res;

    // Status of the command queue as seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: design/pbl_if.sv
// Valid/ready channel interfaces for operation beats and result beats.
// Depends on pbl_pkg for the field widths.
interface pbl_item_if;
    import pbl_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic signed [LABEL_W-1:0]  label;
    logic [ROW_W-1:0]           row;
    modport source (output valid, op, label, row, input ready);
    modport sink (input valid, op, label, row, output ready);
endinterface

interface pbl_result_if;
    import pbl_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [LABEL_W-1:0]  out_label;
    logic [ROW_W-1:0]           row_index;
    logic                       is_member;
    logic                       is_blocked;
    logic                       is_identity;
    logic                       error;
    modport source (output valid, out_label, row_index, is_member, is_blocked,
                    is_identity, error, input ready);
    modport sink (input valid, out_label, row_index, is_member, is_blocked,
                  is_identity, error, output ready);
endinterface

// File: design/pbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/pbl_cmd_q.sv
// Two-entry command queue between the front and back ends.
// Depends on pbl_pkg for t_cmd and t_q_stat.
module pbl_cmd_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pbl_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output pbl_pkg::t_cmd o_cmd,
    output pbl_pkg::t_q_stat o_stat
);
    import pbl_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    assign o_cmd        = r_slot[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
endmodule

// File: design/pbl_front.sv
// Front end: takes operation beats and classifies them into back-end commands.
// Depends on pbl_pkg and pbl_item_if.
module pbl_front #(
    parameter int ROWS    = 16,
    parameter int COLUMNS = 16
) (
    pbl_item_if.sink          i_item,
    input  pbl_pkg::t_q_stat  i_stat,
    output logic              o_push,
    output pbl_pkg::t_cmd     o_cmd
);
    import pbl_pkg::*;

    logic signed [LABEL_W:0] lab_x;
    logic                    lab_ok;
    logic                    row_ok;

    assign lab_x  = {i_item.label[LABEL_W-1], i_item.label};
    assign lab_ok = ((lab_x < 0) && (int'(lab_x) >= -ROWS))
                 || ((lab_x > 0) && (int'(lab_x) <= COLUMNS));
    assign row_ok = (i_item.row != '0) && (int'(i_item.row) <= ROWS);

    assign i_item.ready = !i_stat.full;
    assign o_push       = i_item.valid && !i_stat.full;

    always_comb begin
        o_cmd.label = i_item.label;
        o_cmd.row   = i_item.row;
        case (i_item.op)
            OP_PIVOT:  o_cmd.kind = (lab_ok && row_ok) ? K_PIVOT : K_ERROR;
            OP_FIND:   o_cmd.kind = lab_ok ? K_LOOKUP : K_ERROR;
            OP_READ:   o_cmd.kind = row_ok ? K_READ : K_EMPTY;
            OP_MARK:   o_cmd.kind = lab_ok ? K_MARK : K_EMPTY;
            OP_UNMARK: o_cmd.kind = lab_ok ? K_UNMARK : K_EMPTY;
            OP_QUERY:  o_cmd.kind = lab_ok ? K_LOOKUP : K_EMPTY;
            // unused codes behave as query
            default:   o_cmd.kind = lab_ok ? K_LOOKUP : K_EMPTY;
        endcase
    end
endmodule

// File: design/pbl_back.sv
// Back end: runs commands against the row-label and label-map RAMs and
// holds the result register. Depends on pbl_pkg, pbl_ram, pbl_result_if.
module pbl_back #(
    parameter int ROWS    = 16,
    parameter int COLUMNS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbl_pkg::t_cmd     i_cmd,
    input  pbl_pkg::t_q_stat  i_stat,
    output logic              o_pop,
    pbl_result_if.source      o_result
);
    import pbl_pkg::*;

    localparam int LM_DEPTH = ROWS + COLUMNS;
    localparam int LM_AW    = (LM_DEPTH > 1) ? $clog2(LM_DEPTH) : 1;
    localparam int RL_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LM_W     = $bits(t_lm);
    localparam int CW       = $clog2(ROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RD1,
        S_RD2,
        S_PV1,
        S_PV2
    } t_state;

    // Slack -k lives at k-1, regular column c at ROWS+c-1.
    function automatic logic [LM_AW-1:0] lm_addr(input logic signed [LABEL_W-1:0] lab);
        logic signed [LABEL_W:0] x;
        x = {lab[LABEL_W-1], lab};
        if (x < 0) begin
            return LM_AW'(-int'(x) - 1);
        end
        return LM_AW'(ROWS + int'(x) - 1);
    endfunction

    function automatic t_lm lm_rst(input logic [LM_AW-1:0] a);
        t_lm v;
        v = '0;
        if (int'(a) < ROWS) begin
            v.row = ROW_W'(int'(a) + 1);
        end
        return v;
    endfunction

    function automatic logic [LABEL_W-1:0] rl_rst(input logic [RL_AW-1:0] a);
        return LABEL_W'(-(int'(a) + 1));
    endfunction

    t_state                     r_state, n_state;
    t_cmd                       r_cmd, n_cmd;
    logic signed [LABEL_W-1:0]  r_leave, n_leave;
    logic                       r_blk, n_blk;
    logic [CW-1:0]              r_cnt, n_cnt;
    t_res                       r_res, n_res;
    logic                       r_res_vld, n_res_vld;

    logic                r_lm_vld [LM_DEPTH];
    logic                r_rl_vld [ROWS];
    logic                r_lm_rv, r_rl_rv;
    logic [LM_AW-1:0]    r_lm_ra;
    logic [RL_AW-1:0]    r_rl_ra;

    logic                lm_we, rl_we;
    logic [LM_AW-1:0]    lm_waddr, lm_raddr;
    logic [RL_AW-1:0]    rl_waddr, rl_raddr;
    t_lm                 lm_wdata, lm_q;
    logic [LM_W-1:0]     lm_raw;
    logic [LABEL_W-1:0]  rl_wdata, rl_raw;
    logic signed [LABEL_W-1:0] rl_q;
    logic                take;
    logic signed [LABEL_W:0] neg_row, lv_x, lb_x;
    logic                was_mis, now_mis;

    pbl_ram #(.WIDTH(LM_W), .DEPTH(LM_DEPTH)) u_lm_ram (
        .i_clk   (i_clk),
        .i_we    (lm_we),
        .i_waddr (lm_waddr),
        .i_wdata (lm_wdata),
        .i_raddr (lm_raddr),
        .o_rdata (lm_raw)
    );

    pbl_ram #(.WIDTH(LABEL_W), .DEPTH(ROWS)) u_rl_ram (
        .i_clk   (i_clk),
        .i_we    (rl_we),
        .i_waddr (rl_waddr),
        .i_wdata (rl_wdata),
        .i_raddr (rl_raddr),
        .o_rdata (rl_raw)
    );

    // Entries never written read as their reset value.
    assign lm_q = r_lm_rv ? t_lm'(lm_raw) : lm_rst(r_lm_ra);
    assign rl_q = r_rl_rv ? rl_raw : rl_rst(r_rl_ra);

    assign take  = r_res_vld && o_result.ready;
    assign o_pop = (r_state == S_IDLE) && !i_stat.empty && (!r_res_vld || take);

    assign neg_row = -$signed({2'b00, r_cmd.row});
    assign lv_x    = {rl_q[LABEL_W-1], rl_q};
    assign lb_x    = {r_cmd.label[LABEL_W-1], r_cmd.label};
    assign was_mis = (lv_x != neg_row);
    assign now_mis = (lb_x != neg_row);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_leave   = r_leave;
        n_blk     = r_blk;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_res_vld = r_res_vld && !take;
        lm_we     = 1'b0;
        lm_waddr  = lm_addr(r_cmd.label);
        lm_wdata  = lm_q;
        lm_raddr  = lm_addr(r_cmd.label);
        rl_we     = 1'b0;
        rl_waddr  = RL_AW'(int'(r_cmd.row) - 1);
        rl_wdata  = r_cmd.label;
        rl_raddr  = RL_AW'(int'(i_cmd.row) - 1);

        case (r_state)
            S_IDLE: begin
                lm_raddr = lm_addr(i_cmd.label);
                if (o_pop) begin
                    n_cmd = i_cmd;
                    case (i_cmd.kind)
                        K_PIVOT:  n_state = S_PV1;
                        K_READ:   n_state = S_RD1;
                        K_LOOKUP, K_MARK, K_UNMARK: n_state = S_LOOK;
                        default: begin
                            // error or empty: report at once
                            n_res             = '0;
                            n_res.is_identity = (r_cnt == '0);
                            n_res.error       = (i_cmd.kind == K_ERROR);
                            n_res_vld         = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_res             = '0;
                n_res.row_index   = lm_q.row;
                n_res.is_member   = (lm_q.row != '0);
                n_res.is_blocked  = lm_q.blk;
                n_res.is_identity = (r_cnt == '0);
                if (r_cmd.kind == K_MARK || r_cmd.kind == K_UNMARK) begin
                    lm_we            = 1'b1;
                    lm_wdata.blk     = (r_cmd.kind == K_MARK);
                    n_res.is_blocked = (r_cmd.kind == K_MARK);
                end
                n_res_vld = 1'b1;
                n_state   = S_IDLE;
            end
            S_RD1: begin
                // look up the map entry of the label held in the row
                lm_raddr = lm_addr(rl_q);
                n_leave  = rl_q;
                n_state  = S_RD2;
            end
            S_RD2: begin
                n_res             = '0;
                n_res.out_label   = r_leave;
                n_res.row_index   = lm_q.row;
                n_res.is_member   = (lm_q.row != '0);
                n_res.is_blocked  = lm_q.blk;
                n_res.is_identity = (r_cnt == '0);
                n_res_vld         = 1'b1;
                n_state           = S_IDLE;
            end
            S_PV1: begin
                // enter the label into the row, fetch the leaving entry
                lm_we        = 1'b1;
                lm_wdata.row = r_cmd.row;
                rl_we        = 1'b1;
                lm_raddr     = lm_addr(rl_q);
                n_leave      = rl_q;
                n_blk        = lm_q.blk;
                if (was_mis && !now_mis && r_cnt != '0) begin
                    n_cnt = r_cnt - CW'(1);
                end else if (!was_mis && now_mis) begin
                    n_cnt = r_cnt + CW'(1);
                end
                n_state = S_PV2;
            end
            S_PV2: begin
                // clear the leaving label's row, keep its mark
                lm_we        = 1'b1;
                lm_waddr     = lm_addr(r_leave);
                lm_wdata.row = '0;
                n_res             = '0;
                n_res.out_label   = r_leave;
                n_res.row_index   = (r_leave == r_cmd.label) ? '0 : r_cmd.row;
                n_res.is_member   = (r_leave != r_cmd.label);
                n_res.is_blocked  = r_blk;
                n_res.is_identity = (r_cnt == '0);
                n_res_vld         = 1'b1;
                n_state           = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_res_vld <= n_res_vld;
        end
        r_cmd   <= n_cmd;
        r_leave <= n_leave;
        r_blk   <= n_blk;
        r_res   <= n_res;
    end

    // Written marks; sample them alongside each RAM read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LM_DEPTH; i++) begin
                r_lm_vld[i] <= 1'b0;
            end
            for (int i = 0; i < ROWS; i++) begin
                r_rl_vld[i] <= 1'b0;
            end
        end else begin
            if (lm_we) begin
                r_lm_vld[lm_waddr] <= 1'b1;
            end
            if (rl_we) begin
                r_rl_vld[rl_waddr] <= 1'b1;
            end
        end
        r_lm_rv <= r_lm_vld[lm_raddr];
        r_lm_ra <= lm_raddr;
        r_rl_rv <= r_rl_vld[rl_raddr];
        r_rl_ra <= rl_raddr;
    end

    assign o_result.valid       = r_res_vld;
    assign o_result.out_label   = r_res.out_label;
    assign o_result.row_index   = r_res.row_index;
    assign o_result.is_member   = r_res.is_member;
    assign o_result.is_blocked  = r_res.is_blocked;
    assign o_result.is_identity = r_res.is_identity;
    assign o_result.error       = r_res.error;
endmodule

// File: design/pivot_basis_label_map_core.sv
// Top level of the pivot basis label map: front end, command queue, back end.
// Depends on pbl_pkg, pbl_if, pbl_front, pbl_cmd_q, pbl_back.
//
//   port       dir  beat contents
//   i_item     in   op, label, row
//   o_result   out  out_label, row_index, is_member, is_blocked, is_identity, error
//
// In the back end an invalid pivot/find or a no-op is answered straight from idle;
// find, query, mark and unmark pass through S_LOOK, row read through S_RD1 and
// S_RD2, and pivot through S_PV1 and S_PV2. Pivot and row read need a second
// label-map read whose address comes out of the registered row-label RAM read.
// Reset is synchronous, active low; it clears control state and written marks,
// so no clearing pass is needed. While a result waits on o_result the two-entry
// queue still takes up to two beats on i_item; after that i_item.ready drops.
module pivot_basis_label_map_core #(
    parameter int ROWS    = 16,
    parameter int COLUMNS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pbl_item_if.sink      i_item,
    pbl_result_if.source  o_result
);
    import pbl_pkg::*;

    logic    push;
    logic    pop;
    t_cmd    cmd_in;
    t_cmd    cmd_out;
    t_q_stat q_stat;

    pbl_front #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_front (
        .i_item (i_item),
        .i_stat (q_stat),
        .o_push (push),
        .o_cmd  (cmd_in)
    );

    pbl_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_stat  (q_stat)
    );

    pbl_back #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_out),
        .i_stat   (q_stat),
        .o_pop    (pop),
        .o_result (o_result)
    );
endmodule
